// ===== rtl/d2r_pkg.sv =====
`default_nettype none

package d2r_pkg;

   // field widths
   localparam int VALUE_W  = 12;
   localparam int SYMBOL_W = 8;
   localparam int STEPS    = 13;
   localparam int STEP_W   = 4;

   localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

   // ascii letters
   localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;
   localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;
   localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
   localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
   localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
   localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
   localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
   localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;

   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [SYMBOL_W-1:0] symbol_type;

   // greedy table, largest weight first
   localparam value_type ROMAN_WEIGHT [STEPS] = '{
      12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
      12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
   };
   localparam symbol_type ROMAN_FIRST [STEPS] = '{
      SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
      SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I
   };
   localparam symbol_type ROMAN_SECOND [STEPS] = '{
      SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C, SYM_NONE,
      SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V, SYM_NONE
   };

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic final_char;
   } stat_type;

   // index of the largest table weight not above the remainder
   function automatic logic [STEP_W-1:0] pick_step(input value_type rest);
      logic [STEP_W-1:0] idx;
      idx = STEP_W'(STEPS - 1);
      for (int t = STEPS - 1; t >= 0; t--) begin
         if (rest >= ROMAN_WEIGHT[t]) begin
            idx = STEP_W'(t);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/d2r_ctrl.sv =====
`default_nettype none

module d2r_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  d2r_pkg::stat_type    stat,
   output d2r_pkg::cmd_type     cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   // handshake and commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.step  = (state_ff == ST_RUN) && stat.out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.out_free && stat.final_char) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/d2r_datapath.sv =====
`default_nettype none

module d2r_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire d2r_pkg::value_type  value,
   input  wire d2r_pkg::cmd_type    cmd,
   output d2r_pkg::stat_type        stat,
   output d2r_pkg::symbol_type      out_symbol,
   output logic                     out_last,
   output logic                     out_error,
   output logic                     out_valid,
   input  wire logic                out_ready
);

   d2r_pkg::value_type  rest_ff, rest_in;
   logic                err_ff, err_in;
   logic                pend_ff, pend_in;
   d2r_pkg::symbol_type pend_sym_ff, pend_sym_in;

   logic                valid_ff, valid_in;
   d2r_pkg::symbol_type sym_ff, sym_in;
   logic                last_ff, last_in;
   logic                error_ff, error_in;

   logic [d2r_pkg::STEP_W-1:0] idx;
   d2r_pkg::value_type         rest_sub;
   logic                       is_pair;
   logic                       final_char;

   // greedy choice for the current remainder
   always_comb begin
      idx      = d2r_pkg::pick_step(rest_ff);
      rest_sub = rest_ff - d2r_pkg::ROMAN_WEIGHT[idx];
      is_pair  = (d2r_pkg::ROMAN_SECOND[idx] != d2r_pkg::SYM_NONE);
      if (err_ff) begin
         final_char = 1'b1;
      end else if (pend_ff) begin
         final_char = (rest_ff == '0);
      end else begin
         final_char = !is_pair && (rest_sub == '0);
      end
   end

   assign stat.out_free   = !valid_ff || out_ready;
   assign stat.final_char = final_char;

   // remainder, pending second letter and output register
   always_comb begin
      rest_in     = rest_ff;
      err_in      = err_ff;
      pend_in     = pend_ff;
      pend_sym_in = pend_sym_ff;
      valid_in    = valid_ff && !out_ready;
      sym_in      = sym_ff;
      last_in     = last_ff;
      error_in    = error_ff;
      if (cmd.load) begin
         rest_in = value;
         err_in  = (value == '0) || (value > d2r_pkg::MAX_VALUE);
         pend_in = 1'b0;
      end else if (cmd.step) begin
         valid_in = 1'b1;
         last_in  = final_char;
         error_in = err_ff;
         if (err_ff) begin
            sym_in = d2r_pkg::SYM_NONE;
         end else if (pend_ff) begin
            sym_in  = pend_sym_ff;
            pend_in = 1'b0;
         end else begin
            sym_in      = d2r_pkg::ROMAN_FIRST[idx];
            pend_in     = is_pair;
            pend_sym_in = d2r_pkg::ROMAN_SECOND[idx];
            rest_in     = rest_sub;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff     <= rest_in;
      pend_sym_ff <= pend_sym_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      error_ff    <= error_in;
   end

   assign out_valid  = valid_ff;
   assign out_symbol = sym_ff;
   assign out_last   = last_ff;
   assign out_error  = error_ff;

endmodule

`default_nettype wire

// ===== rtl/decimal_to_roman_encoder_top.sv =====
// Converts a 12-bit unsigned integer into its Roman numeral, sent as a run of
// ASCII letters, most significant first, one per response beat, with tlast on
// the final letter; subtractive pairs (IV, IX, XL, XC, CD, CM) are used. An
// input of 0 or above 3999 gives a single beat with symbol 0 and the error
// flag in tuser set. A request is loaded first; then the letter sequencer
// produces one letter per cycle into the output register, whenever that
// register is free (empty or read by the receiver); a new request is taken
// as soon as the last letter of the previous one sits in that register.
`default_nettype none

module decimal_to_roman_encoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // value[11:0], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // symbol[7:0]
   output logic             rsp_tlast,
   output logic             rsp_tuser    // error
);

   d2r_pkg::cmd_type    cmd;
   d2r_pkg::stat_type   stat;
   d2r_pkg::symbol_type symbol;

   // sequencing of load and letter steps
   d2r_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // remainder, letter choice and output register
   d2r_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[d2r_pkg::VALUE_W-1:0]),
      .cmd        (cmd),
      .stat       (stat),
      .out_symbol (symbol),
      .out_last   (rsp_tlast),
      .out_error  (rsp_tuser),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = symbol;

endmodule

`default_nettype wire

// ===== bench/tb_decimal_to_roman_encoder_top.sv =====
`timescale 1ns / 1ps

module tb_decimal_to_roman_encoder_top;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct {
      d2r_pkg::symbol_type symbol;
      logic                last;
      logic                error;
   } roman_letter_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;     // value[11:0], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // symbol[7:0]
   logic        rsp_tlast;
   logic        rsp_tuser;          // error

   roman_letter_type pending_letters[$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               burst_left = 0;
   int               stall_mode = 0;
   int               stall_phase = 0;
   int               stall_tick = 0;

   decimal_to_roman_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // expected letters of one numeral, built digit by digit
   function automatic void predict_numeral(input d2r_pkg::value_type v);
      d2r_pkg::symbol_type ones [4];
      d2r_pkg::symbol_type fives [4];
      d2r_pkg::symbol_type tens [4];
      d2r_pkg::symbol_type chars[$];
      int                  rest;
      int                  d;
      int                  scale;
      ones  = '{d2r_pkg::SYM_I, d2r_pkg::SYM_X, d2r_pkg::SYM_C, d2r_pkg::SYM_M};
      fives = '{d2r_pkg::SYM_V, d2r_pkg::SYM_L, d2r_pkg::SYM_D, d2r_pkg::SYM_NONE};
      tens  = '{d2r_pkg::SYM_X, d2r_pkg::SYM_C, d2r_pkg::SYM_M, d2r_pkg::SYM_NONE};
      rest  = int'(v);
      if (rest == 0 || rest > 3999) begin
         pending_letters.push_back('{d2r_pkg::SYM_NONE, 1'b1, 1'b1});
         return;
      end
      scale = 1000;
      for (int p = 3; p >= 0; p--) begin
         d = (rest / scale) % 10;
         case (d)
            4: begin
               chars.push_back(ones[p]);
               chars.push_back(fives[p]);
            end
            9: begin
               chars.push_back(ones[p]);
               chars.push_back(tens[p]);
            end
            default: begin
               if (d >= 5) chars.push_back(fives[p]);
               for (int k = 0; k < d % 5; k++) chars.push_back(ones[p]);
            end
         endcase
         scale = scale / 10;
      end
      foreach (chars[k])
         pending_letters.push_back('{chars[k], k == chars.size() - 1, 1'b0});
   endfunction

   // offer one request, wait for it to be taken, then pace the next one
   task automatic send_value(input d2r_pkg::value_type v);
      req_tdata  <= {4'b0000, v};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_numeral(v);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // zero, the edges of the legal range and the top of the field
   task automatic test_range_limits;
      send_value(12'd0);
      send_value(12'd1);
      send_value(12'd3999);
      send_value(12'd4000);
      send_value(12'd4095);
   endtask

   // every subtractive pair, including the four hundreds
   task automatic test_subtractive_pairs;
      send_value(12'd4);
      send_value(12'd9);
      send_value(12'd40);
      send_value(12'd90);
      send_value(12'd400);
      send_value(12'd900);
      send_value(12'd499);
      send_value(12'd1994);
   endtask

   // the longest numeral (fifteen letters) and long runs of repeats
   task automatic test_longest_numerals;
      send_value(12'd3888);
      send_value(12'd2888);
      send_value(12'd3333);
   endtask

   // alternating and single-bit values, and single-letter numerals
   task automatic test_bit_patterns;
      send_value(12'h555);
      send_value(12'hAAA);
      send_value(12'h800);
      send_value(12'd1000);
      send_value(12'd5);
   endtask

   // mostly legal values, some letter-heavy, some out of range
   task automatic test_random_values;
      int                 heavy [3] = '{3, 7, 8};
      int                 pick;
      d2r_pkg::value_type v;
      for (int n = 0; n < 290; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            v = d2r_pkg::value_type'($urandom_range(1, 3999));
         end else if (pick < 80) begin
            v = d2r_pkg::value_type'($urandom_range(0, 3) * 1000
                                     + heavy[$urandom_range(0, 2)] * 100
                                     + heavy[$urandom_range(0, 2)] * 10
                                     + heavy[$urandom_range(0, 2)]);
         end else if (pick < 90) begin
            if ($urandom_range(0, 4) == 0) begin
               v = d2r_pkg::value_type'(0);
            end else begin
               v = d2r_pkg::value_type'($urandom_range(4000, 4095));
            end
         end else begin
            v = d2r_pkg::value_type'($urandom_range(0, 4095));
         end
         send_value(v);
      end
   endtask

   // receiver stalls in phases: none, random, periodic and heavy
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_phase = $urandom_range(20, 80);
      end else begin
         stall_phase--;
      end
      stall_tick++;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= (stall_tick % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 6) == 0);
      endcase
   end

   // compare each letter with the oldest expectation
   always @(posedge clock) begin
      roman_letter_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_letters.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected letter: symbol %h last %b error %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = pending_letters.pop_front();
            if (rsp_tdata !== want.symbol || rsp_tlast !== want.last
                || rsp_tuser !== want.error) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected symbol %h last %b error %b, got %h %b %b",
                           want.symbol, want.last, want.error,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   // watchdog on cycles with no request or letter moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_range_limits();
      test_subtractive_pairs();
      test_longest_numerals();
      test_bit_patterns();
      test_random_values();
      req_tvalid <= 1'b0;
      // drain, then give stray letters a chance to show
      while (pending_letters.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_letters.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
